### sv/drm_pkg.sv
// drm_pkg: shared command codes, status codes and the result struct of the
// ordered ring store with remove-all-maximum.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package drm_pkg;

    // Field widths of one beat
    localparam int W_CMD   = 2;
    localparam int W_VALUE = 32;
    localparam int W_CNT   = 6;

    // Command codes
    localparam logic [W_CMD-1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [W_CMD-1:0] CMD_PUSH_BACK  = 2'd1;
    localparam logic [W_CMD-1:0] CMD_REMOVE_MAX = 2'd2;
    localparam logic [W_CMD-1:0] CMD_CLEAR      = 2'd3;

    // Status codes
    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FULL = 1'b1;

    // One result beat as it leaves the sequencer
    typedef struct packed {
        logic             valid;
        logic             status;
        logic [W_CNT-1:0] removed_count;
        logic [W_CNT-1:0] stored_count;
    } t_res;

endpackage

`default_nettype wire

### sv/drm_ram.sv
// drm_ram: ring storage, one write port and one read port, registered read.
// Depends on drm_pkg; entries have no reset.
`timescale 1ns / 1ps
`default_nettype none

module drm_ram #(
    parameter int DEPTH = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [drm_pkg::W_VALUE-1:0]            i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [drm_pkg::W_VALUE-1:0]            o_rdata
);

    logic [drm_pkg::W_VALUE-1:0] r_mem [DEPTH];
    logic [drm_pkg::W_VALUE-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/drm_ctrl.sv
// drm_ctrl: command sequencer. Holds head and count, runs the max scan and
// the in-order compaction over the ring memory.
// Depends on drm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drm_ctrl #(
    parameter int DEPTH = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_accept,
    input  wire logic [drm_pkg::W_CMD-1:0]              i_command,
    input  wire logic signed [drm_pkg::W_VALUE-1:0]     i_value,
    input  wire logic                                   i_res_free,
    output logic                                        o_ready,
    output drm_pkg::t_res                               o_res,
    output logic                                        o_we,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] o_waddr,
    output logic [drm_pkg::W_VALUE-1:0]                 o_wdata,
    output logic                                        o_re,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] o_raddr,
    input  wire logic [drm_pkg::W_VALUE-1:0]            i_rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   DEPTH_S   = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_PACK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // ring slot of position pos from the front
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] pos);
        logic [CW:0] sum;
        sum = (CW + 1)'(head) + {1'b0, pos};
        if (sum >= DEPTH_S) begin
            sum = sum - DEPTH_S;
        end
        return sum[AW-1:0];
    endfunction

    logic [1:0]                    r_state, n_state;
    logic [AW-1:0]                 r_head, n_head;
    logic [CW-1:0]                 r_count, n_count;
    logic [CW-1:0]                 r_idx, n_idx;
    logic [CW-1:0]                 r_keep, n_keep;
    logic [CW-1:0]                 r_removed, n_removed;
    logic signed [drm_pkg::W_VALUE-1:0] r_max, n_max;
    logic                          r_first, n_first;
    logic                          r_rv, n_rv;

    logic                          idle, full, is_last, issue;
    logic                          hit, keep_wr, is_push;
    logic [AW-1:0]                 head_dec;
    logic [CW-1:0]                 keep_sum;

    assign idle     = (r_state == S_IDLE);
    assign full     = (r_count == DEPTH_C);
    assign is_last  = (r_idx == r_count);
    assign issue    = ((r_state == S_SCAN) || (r_state == S_PACK)) && !is_last;
    assign head_dec = (r_head == '0) ? LAST_SLOT : r_head - 1'b1;
    assign is_push  = (i_command == drm_pkg::CMD_PUSH_FRONT)
                   || (i_command == drm_pkg::CMD_PUSH_BACK);

    // comparators: greater-than finds a new maximum while scanning, inequality a survivor while packing
    assign hit      = r_rv && (r_first || ($signed(i_rd_data) > r_max));
    assign keep_wr  = (r_state == S_PACK) && r_rv && (i_rd_data != r_max);
    assign keep_sum = r_keep + CW'(keep_wr);

    assign o_ready  = idle && i_res_free;

    // read port walks the ring from the front
    assign o_re     = issue;
    assign o_raddr  = slot_of(r_head, r_idx);

    // write port: pushes from idle, survivors while packing
    always_comb begin
        o_we    = 1'b0;
        o_waddr = slot_of(r_head, r_keep);
        o_wdata = i_rd_data;
        if (idle && i_accept && !full && (i_command == drm_pkg::CMD_PUSH_FRONT)) begin
            o_we    = 1'b1;
            o_waddr = head_dec;
            o_wdata = i_value;
        end else if (idle && i_accept && !full
                     && (i_command == drm_pkg::CMD_PUSH_BACK)) begin
            o_we    = 1'b1;
            o_waddr = slot_of(r_head, r_count);
            o_wdata = i_value;
        end else if (keep_wr) begin
            o_we    = 1'b1;
        end
    end

    // sequencer next state
    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_idx     = r_idx;
        n_keep    = r_keep;
        n_removed = r_removed;
        n_max     = r_max;
        n_first   = r_first;
        n_rv      = issue;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    unique case (i_command)
                        drm_pkg::CMD_PUSH_FRONT: begin
                            if (!full) begin
                                n_head  = head_dec;
                                n_count = r_count + 1'b1;
                            end
                        end
                        drm_pkg::CMD_PUSH_BACK: begin
                            if (!full) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        drm_pkg::CMD_REMOVE_MAX: begin
                            if (r_count != '0) begin
                                n_state = S_SCAN;
                                n_idx   = '0;
                                n_first = 1'b1;
                            end
                        end
                        default: begin
                            n_count = '0;
                            n_head  = '0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (hit) begin
                    n_max   = $signed(i_rd_data);
                    n_first = 1'b0;
                end
                // last read data is consumed in this cycle
                if (is_last) begin
                    n_state = S_PACK;
                    n_idx   = '0;
                    n_keep  = '0;
                end
            end
            S_PACK: begin
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                n_keep = keep_sum;
                if (is_last) begin
                    n_count   = keep_sum;
                    n_removed = r_count - keep_sum;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result beat
    always_comb begin
        o_res.valid = (idle && i_accept && (i_command != drm_pkg::CMD_REMOVE_MAX))
                   || (idle && i_accept && (i_command == drm_pkg::CMD_REMOVE_MAX)
                       && (r_count == '0))
                   || ((r_state == S_DONE) && i_res_free);
        o_res.status        = (idle && is_push && full) ? drm_pkg::ST_FULL
                                                        : drm_pkg::ST_DONE;
        o_res.removed_count = (r_state == S_DONE) ? drm_pkg::W_CNT'(r_removed)
                                                  : '0;
        o_res.stored_count  = drm_pkg::W_CNT'(n_count);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_rv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_rv    <= n_rv;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_keep    <= n_keep;
        r_removed <= n_removed;
        r_max     <= n_max;
        r_first   <= n_first;
    end

endmodule

`default_nettype wire

### sv/deque_remove_all_max_core.sv
// deque_remove_all_max_core: top level of the ordered ring store.
// Depends on drm_pkg, drm_ram and drm_ctrl.
`timescale 1ns / 1ps
`default_nettype none

// Ordered store of up to DEPTH signed 32-bit values in a ring memory. Push
// front, push back and clear are taken while idle; their result beat passes
// the pending result register and then the output register. Remove-all-max
// on a non-empty store stalls the input until it is done: the single read
// port of the ring memory walks every entry once to find the maximum and
// once more to compact the survivors in order. On an empty store it answers
// like a push, with no scan. A pending result register and the output
// register decouple the two channels, so a new beat is taken while one
// result still waits in the output register; with both full the input stalls.
module deque_remove_all_max_core #(
    parameter int DEPTH = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [drm_pkg::W_CMD-1:0]          i_command,
    input  wire logic signed [drm_pkg::W_VALUE-1:0] i_value,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic                                    o_status,
    output logic      [drm_pkg::W_CNT-1:0]          o_removed_count,
    output logic      [drm_pkg::W_CNT-1:0]          o_stored_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                        ready, accept, out_free, res_free;
    drm_pkg::t_res               res;
    drm_pkg::t_res               r_pend, r_out;
    logic                        r_pv, r_ov;
    logic                        we, re;
    logic [AW-1:0]               waddr, raddr;
    logic [drm_pkg::W_VALUE-1:0] wdata, rdata;

    // handshake
    assign out_free = !r_ov || !i_stall;
    assign res_free = !r_pv || out_free;
    assign o_stall  = !ready;
    assign accept   = i_valid && ready;

    drm_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_command  (i_command),
        .i_value    (i_value),
        .i_res_free (res_free),
        .o_ready    (ready),
        .o_res      (res),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_re       (re),
        .o_raddr    (raddr),
        .i_rd_data  (rdata)
    );

    drm_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // pending and output valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (out_free) begin
                r_ov <= r_pv;
            end
            if (res.valid) begin
                r_pv <= 1'b1;
            end else if (out_free) begin
                r_pv <= 1'b0;
            end
        end
    end

    // result payload stages
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_pend;
        end
        if (res.valid) begin
            r_pend <= res;
        end
    end

    assign o_valid         = r_ov;
    assign o_status        = r_out.status;
    assign o_removed_count = r_out.removed_count;
    assign o_stored_count  = r_out.stored_count;

endmodule

`default_nettype wire

### sv/drm_checker.sv
// drm_checker: port-level checks of the ordered ring store, bound to the top.
// Depends on drm_pkg and deque_remove_all_max_core.
`timescale 1ns / 1ps
`default_nettype none

module drm_checker #(
    parameter int DEPTH = 32
) (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_valid,
    input wire logic                               o_stall,
    input wire logic [drm_pkg::W_CMD-1:0]          i_command,
    input wire logic signed [drm_pkg::W_VALUE-1:0] i_value,
    input wire logic                               o_valid,
    input wire logic                               i_stall,
    input wire logic                               o_status,
    input wire logic [drm_pkg::W_CNT-1:0]          o_removed_count,
    input wire logic [drm_pkg::W_CNT-1:0]          o_stored_count
);

    localparam logic [drm_pkg::W_CNT:0] DEPTH_W = (drm_pkg::W_CNT + 1)'(DEPTH);
    localparam logic                    SMALL   = (DEPTH < 64);

    // a stalled input beat holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_command) && $stable(i_value))
        else $error("input beat changed while stalled");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)
            && $stable(o_removed_count) && $stable(o_stored_count))
        else $error("result beat changed while stalled");

    // a refused push removes nothing and reports a full store
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == drm_pkg::ST_FULL) |->
            (o_removed_count == '0)
            && (o_stored_count == drm_pkg::W_CNT'(DEPTH)))
        else $error("refused push with wrong counts");

    // held entries never exceed the ring size
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && SMALL |->
            ({1'b0, o_stored_count} + {1'b0, o_removed_count}) <= DEPTH_W)
        else $error("stored plus removed exceeds depth");

    // a remove-max beat never leaves the store grown past the ring size
    a_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && SMALL && (o_removed_count != '0) |->
            (o_status == drm_pkg::ST_DONE) && ({1'b0, o_stored_count} < DEPTH_W))
        else $error("remove-max beat with bad status or count");

endmodule

bind deque_remove_all_max_core drm_checker #(
    .DEPTH (DEPTH)
) u_drm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_command       (i_command),
    .i_value         (i_value),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_status        (o_status),
    .o_removed_count (o_removed_count),
    .o_stored_count  (o_stored_count)
);

`default_nettype wire
